@@ rtl/wms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the waypoint mission sequencer.
// Used by wms_step, waypoint_mission_sequencer_core and wms_checker; no dependencies.
package wms_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int TAG_BITS      = 8;
    localparam int ROUTE_CAP_INT = (MAX_WAYPOINTS < 256) ? MAX_WAYPOINTS : 256;
    localparam logic [8:0] ROUTE_CAP = 9'(ROUTE_CAP_INT);
    localparam int APB_ADDR_W    = 5;

    typedef enum logic [2:0] {
        MODE_WAIT   = 3'd0,
        MODE_IDLE   = 3'd1,
        MODE_PATROL = 3'd2,
        MODE_RETURN = 3'd3,
        MODE_CHARGE = 3'd4,
        MODE_FINISH = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_REJECT  = 3'd3,
        CMD_SUCCEED = 3'd4,
        CMD_FAIL    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        OVR_NONE = 2'd0,
        OVR_ON   = 2'd1,
        OVR_OFF  = 2'd2
    } ovr_t;

    typedef enum logic [2:0] {
        REG_AUTOSTART   = 3'd0,
        REG_LOOP_ENABLE = 3'd1,
        REG_LOOP_LIMIT  = 3'd2,
        REG_RETRY_LIMIT = 3'd3,
        REG_RETRY_WAIT  = 3'd4,
        REG_WP_TOTAL    = 3'd5
    } reg_addr_t;

    typedef struct packed {
        logic        autostart_enable;
        logic        loop_enable;
        logic [7:0]  loop_limit;
        logic [3:0]  retry_limit;
        logic [15:0] retry_wait_ticks;
        logic [8:0]  waypoint_total;
    } cfg_t;

    typedef struct packed {
        logic [2:0] command;
        logic       nav_ready;
        logic       battery_low;
        logic       battery_charged;
        logic [7:0] event_tag;
    } req_t;

    typedef struct packed {
        mode_t               mode;
        ovr_t                start_override;
        logic [7:0]          route_index;
        logic [7:0]          loop_count;
        logic [4:0]          retry_count;
        logic [15:0]         wait_count;
        logic [TAG_BITS-1:0] tag_counter;
        logic                goal_outstanding;
    } state_t;

    typedef struct packed {
        logic [2:0] mission_state;
        logic       issue_goal;
        logic       goal_is_dock;
        logic [7:0] goal_waypoint;
        logic [7:0] goal_tag;
        logic       cancel_goals;
        logic       command_accepted;
        logic       goal_busy;
        logic       charging;
        logic [7:0] loops_done;
        logic [7:0] waypoint_now;
    } res_t;

endpackage

@@ rtl/wms_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one mission request.
// Depends on wms_pkg.
module wms_step
    import wms_pkg::*;
(
    input  state_t st,
    input  cfg_t   cfg,
    input  req_t   req,
    output state_t st_next,
    output res_t   res
);

    logic [15:0]         wc_dec;
    logic [8:0]          rsize;
    logic [8:0]          idx_inc;
    logic [7:0]          adv_index;
    logic [7:0]          adv_loop;
    mode_t               adv_mode;
    logic [TAG_BITS-1:0] tag_inc;
    logic [4:0]          rc_inc;
    logic [7:0]          idx;
    logic                go;
    logic                issue;
    logic                dock;
    logic [7:0]          wp;
    logic                cancel;
    logic                accepted;

    always_comb begin
        wc_dec  = (st.wait_count != 16'd0) ? st.wait_count - 16'd1 : st.wait_count;
        tag_inc = st.tag_counter + TAG_BITS'(1);
        rc_inc  = st.retry_count + 5'd1;

        rsize = cfg.waypoint_total;
        if (rsize == 9'd0) begin
            rsize = 9'd1;
        end
        if (rsize > ROUTE_CAP) begin
            rsize = ROUTE_CAP;
        end

        idx_inc   = {1'b0, st.route_index} + 9'd1;
        adv_index = st.route_index + 8'd1;
        adv_loop  = st.loop_count;
        adv_mode  = st.mode;
        if (idx_inc >= rsize) begin
            adv_index = 8'd0;
            if (st.loop_count != 8'hFF) begin
                adv_loop = st.loop_count + 8'd1;
            end
            if (!cfg.loop_enable || (cfg.loop_limit != 8'd0 && adv_loop >= cfg.loop_limit)) begin
                adv_mode = MODE_FINISH;
            end
        end

        idx      = ({1'b0, st.route_index} >= rsize) ? 8'd0 : st.route_index;
        go       = 1'b0;
        st_next  = st;
        issue    = 1'b0;
        dock     = 1'b0;
        wp       = 8'd0;
        cancel   = 1'b0;
        accepted = 1'b0;

        case (req.command)
            CMD_TICK: begin
                st_next.wait_count = wc_dec;
                case (st.mode)
                    MODE_WAIT: begin
                        if (req.nav_ready) begin
                            case (st.start_override)
                                OVR_ON:  go = 1'b1;
                                OVR_OFF: go = 1'b0;
                                default: go = cfg.autostart_enable;
                            endcase
                            st_next.wait_count = 16'd0;
                            st_next.mode       = go ? MODE_PATROL : MODE_IDLE;
                        end
                    end
                    MODE_PATROL: begin
                        if (req.battery_low) begin
                            st_next.tag_counter      = tag_inc;
                            st_next.goal_outstanding = 1'b0;
                            st_next.retry_count      = 5'd0;
                            st_next.wait_count       = 16'd0;
                            st_next.mode             = MODE_RETURN;
                        end else if (!st.goal_outstanding && wc_dec == 16'd0) begin
                            st_next.route_index      = idx;
                            st_next.tag_counter      = tag_inc;
                            st_next.goal_outstanding = 1'b1;
                            issue                    = 1'b1;
                            wp                       = idx;
                        end
                    end
                    MODE_RETURN: begin
                        if (!st.goal_outstanding && wc_dec == 16'd0) begin
                            st_next.tag_counter      = tag_inc;
                            st_next.goal_outstanding = 1'b1;
                            issue                    = 1'b1;
                            dock                     = 1'b1;
                        end
                    end
                    MODE_CHARGE: begin
                        if (req.battery_charged) begin
                            st_next.retry_count = 5'd0;
                            st_next.wait_count  = 16'd0;
                            st_next.mode        = MODE_PATROL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_START: begin
                if (st.mode inside {MODE_IDLE, MODE_FINISH}) begin
                    if (st.mode == MODE_FINISH) begin
                        st_next.route_index = 8'd0;
                        st_next.loop_count  = 8'd0;
                    end
                    st_next.retry_count = 5'd0;
                    st_next.wait_count  = 16'd0;
                    st_next.mode        = MODE_PATROL;
                    accepted            = 1'b1;
                end else if (st.mode == MODE_WAIT) begin
                    st_next.start_override = OVR_ON;
                    accepted               = 1'b1;
                end
            end
            CMD_STOP: begin
                if (st.mode == MODE_WAIT) begin
                    st_next.start_override = OVR_OFF;
                    accepted               = 1'b1;
                end else if (!(st.mode inside {MODE_IDLE, MODE_FINISH})) begin
                    cancel                   = st.goal_outstanding;
                    st_next.tag_counter      = tag_inc;
                    st_next.goal_outstanding = 1'b0;
                    st_next.mode             = MODE_IDLE;
                    accepted                 = 1'b1;
                end
            end
            CMD_REJECT, CMD_SUCCEED, CMD_FAIL: begin
                if (st.goal_outstanding && req.event_tag == 8'(st.tag_counter)) begin
                    st_next.goal_outstanding = 1'b0;
                    case (req.command)
                        CMD_REJECT: begin
                            st_next.wait_count = cfg.retry_wait_ticks;
                        end
                        CMD_SUCCEED: begin
                            st_next.retry_count = 5'd0;
                            if (st.mode == MODE_RETURN) begin
                                st_next.mode = MODE_CHARGE;
                            end else begin
                                st_next.route_index = adv_index;
                                st_next.loop_count  = adv_loop;
                                st_next.mode        = adv_mode;
                                st_next.wait_count  = 16'd0;
                            end
                        end
                        default: begin
                            if (rc_inc <= {1'b0, cfg.retry_limit}) begin
                                st_next.retry_count = rc_inc;
                                st_next.wait_count  = cfg.retry_wait_ticks;
                            end else begin
                                st_next.retry_count = 5'd0;
                                if (st.mode == MODE_RETURN) begin
                                    st_next.wait_count = cfg.retry_wait_ticks;
                                end else begin
                                    st_next.route_index = adv_index;
                                    st_next.loop_count  = adv_loop;
                                    st_next.mode        = adv_mode;
                                    st_next.wait_count  = 16'd0;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        res.mission_state    = st_next.mode;
        res.issue_goal       = issue;
        res.goal_is_dock     = dock;
        res.goal_waypoint    = wp;
        res.goal_tag         = 8'(st_next.tag_counter);
        res.cancel_goals     = cancel;
        res.command_accepted = accepted;
        res.goal_busy        = st_next.goal_outstanding;
        res.charging         = (st_next.mode == MODE_CHARGE);
        res.loops_done       = st_next.loop_count;
        res.waypoint_now     = st_next.route_index;
    end

endmodule

@@ rtl/waypoint_mission_sequencer_core.sv @@
`timescale 1ns / 1ps
// Waypoint mission sequencer top level: APB registers, request and result stages.
// Depends on wms_pkg and wms_step.
//
// Usage:
//   Requests (tick, start, stop, goal rejected/succeeded/failed) enter on the s_ channel
//   with valid/ready; each request yields exactly one result on the m_ channel.
//   A request is captured in an input register; once the result stage can advance, the
//   mission state update (wms_step) runs and loads the result register and m_valid.
//   Throughput is one request per cycle: the input register refills in the same
//   cycle that the result register is loaded, so s_ready stays high while the
//   result stage can advance.
//   When m_ready is low with a result held, the input register holds at most one more
//   request, then s_ready drops; nothing is lost or duplicated.
//   Registers sit at byte addresses 4*i on the APB port; pready is always high and a
//   write lands on the access cycle. Write them only while no request is in flight.
//   Synchronous active-low reset empties both stages, sets the mission to waiting for
//   the navigator with all counters and the goal tag at zero, and loads register defaults.
module waypoint_mission_sequencer_core
    import wms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_command,
    input  logic                  s_nav_ready,
    input  logic                  s_battery_low,
    input  logic                  s_battery_charged,
    input  logic [7:0]            s_event_tag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_mission_state,
    output logic                  m_issue_goal,
    output logic                  m_goal_is_dock,
    output logic [7:0]            m_goal_waypoint,
    output logic [7:0]            m_goal_tag,
    output logic                  m_cancel_goals,
    output logic                  m_command_accepted,
    output logic                  m_goal_busy,
    output logic                  m_charging,
    output logic [7:0]            m_loops_done,
    output logic [7:0]            m_waypoint_now
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    req_t      req_reg;
    res_t      res_reg;
    res_t      res_next;
    logic      in_valid_reg;
    logic      m_valid_reg;
    logic      advance;
    logic      cfg_wr;
    reg_addr_t cfg_addr;

    assign pready   = 1'b1;
    assign cfg_addr = reg_addr_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.autostart_enable <= 1'b1;
            cfg_reg.loop_enable      <= 1'b1;
            cfg_reg.loop_limit       <= 8'd0;
            cfg_reg.retry_limit      <= 4'd2;
            cfg_reg.retry_wait_ticks <= 16'd30;
            cfg_reg.waypoint_total   <= 9'd1;
        end else if (cfg_wr) begin
            case (cfg_addr)
                REG_AUTOSTART:   cfg_reg.autostart_enable <= pwdata[0];
                REG_LOOP_ENABLE: cfg_reg.loop_enable      <= pwdata[0];
                REG_LOOP_LIMIT:  cfg_reg.loop_limit       <= pwdata[7:0];
                REG_RETRY_LIMIT: cfg_reg.retry_limit      <= pwdata[3:0];
                REG_RETRY_WAIT:  cfg_reg.retry_wait_ticks <= pwdata[15:0];
                REG_WP_TOTAL:    cfg_reg.waypoint_total   <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_addr)
            REG_AUTOSTART:   prdata = {31'd0, cfg_reg.autostart_enable};
            REG_LOOP_ENABLE: prdata = {31'd0, cfg_reg.loop_enable};
            REG_LOOP_LIMIT:  prdata = {24'd0, cfg_reg.loop_limit};
            REG_RETRY_LIMIT: prdata = {28'd0, cfg_reg.retry_limit};
            REG_RETRY_WAIT:  prdata = {16'd0, cfg_reg.retry_wait_ticks};
            REG_WP_TOTAL:    prdata = {23'd0, cfg_reg.waypoint_total};
            default:         prdata = 32'd0;
        endcase
    end

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg.command         <= s_command;
            req_reg.nav_ready       <= s_nav_ready;
            req_reg.battery_low     <= s_battery_low;
            req_reg.battery_charged <= s_battery_charged;
            req_reg.event_tag       <= s_event_tag;
        end
    end

    wms_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .req     (req_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode             <= MODE_WAIT;
            state_reg.start_override   <= OVR_NONE;
            state_reg.route_index      <= 8'd0;
            state_reg.loop_count       <= 8'd0;
            state_reg.retry_count      <= 5'd0;
            state_reg.wait_count       <= 16'd0;
            state_reg.tag_counter      <= '0;
            state_reg.goal_outstanding <= 1'b0;
            m_valid_reg                <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_mission_state    = res_reg.mission_state;
    assign m_issue_goal       = res_reg.issue_goal;
    assign m_goal_is_dock     = res_reg.goal_is_dock;
    assign m_goal_waypoint    = res_reg.goal_waypoint;
    assign m_goal_tag         = res_reg.goal_tag;
    assign m_cancel_goals     = res_reg.cancel_goals;
    assign m_command_accepted = res_reg.command_accepted;
    assign m_goal_busy        = res_reg.goal_busy;
    assign m_charging         = res_reg.charging;
    assign m_loops_done       = res_reg.loops_done;
    assign m_waypoint_now     = res_reg.waypoint_now;

endmodule

@@ rtl/wms_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for waypoint_mission_sequencer_core, bound to the top level.
// Depends on wms_pkg.
module wms_checker
    import wms_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_mission_state,
    input logic       m_issue_goal,
    input logic       m_goal_is_dock,
    input logic [7:0] m_goal_waypoint,
    input logic [7:0] m_goal_tag,
    input logic       m_cancel_goals,
    input logic       m_command_accepted,
    input logic       m_goal_busy,
    input logic       m_charging
);

    a_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_issue_goal |-> m_goal_busy)
        else $error("issued goal not marked outstanding");

    a_dock_goal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_goal_is_dock |->
            m_issue_goal && m_goal_waypoint == 8'd0 && m_mission_state == MODE_RETURN)
        else $error("dock goal outside return or with waypoint");

    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cancel_goals |->
            m_command_accepted && !m_goal_busy && m_mission_state == MODE_IDLE)
        else $error("cancel without accepted stop to idle");

    a_charging: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_charging |-> m_mission_state == MODE_CHARGE && !m_issue_goal)
        else $error("charging flag out of step with state");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_goal_tag) && $stable(m_mission_state))
        else $error("stalled result changed");

endmodule

bind waypoint_mission_sequencer_core wms_checker u_wms_checker (.*);
